>>> design/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg: shared definitions for the setpoint ramp limiter
// Command codes, configuration register indexes and default sizes.
// ----------------------------------------------------------------------------
package srl_pkg;

    // default sizes of the value and tick paths
    localparam int VALUE_W_DEF = 32;
    localparam int TICK_W_DEF  = 32;

    // rates are unsigned q16.16 per tick
    localparam int              RATE_W     = 32;
    localparam logic [RATE_W-1:0] RATE_RESET = 32'd327680;

    // configuration register indexes
    localparam int             CFG_IDX_W       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE = 2'd2;

    // request command
    typedef enum logic {
        CMD_UPDATE  = 1'b0,
        CMD_REFRESH = 1'b1
    } t_cmd;

endpackage

>>> design/setpoint_ramp_limiter.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_limiter: asymmetric slew-rate limiter for a q16.16 setpoint
// Ramps the output toward the commanded setpoint at separate rise and fall
// rates, with a refresh command that forces the value.
// ----------------------------------------------------------------------------
// usage
//   request channel: i_valid / o_stall with i_cmd, i_target_value, i_tick_now.
//   a request is taken on a clock edge with i_valid high and o_stall low.
//   result channel: o_valid / i_stall with o_output_value, o_at_target; one
//   result per request, in order.
//   config channel: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index
//   and i_cfg_data; index 0 rise rate, 1 fall rate, 2 mirror mode, others are
//   dropped. write only while no request is in flight.
//   a request passes an input register, then the step logic (one rate by ticks
//   multiply, one distance compare, one add or subtract) into the result
//   register. one request per cycle is sustained while the receiver does not
//   stall; the step is combinational, as each request needs the last output.
//   when the receiver stalls, the result register holds; o_stall rises only
//   when both the input register and the result register are occupied.
//   synchronous active-low reset empties both stages, disarms the ramp, sets
//   output and last tick to zero and both rates to 5.0 per tick.
// ----------------------------------------------------------------------------
module setpoint_ramp_limiter
    import srl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TICK_WIDTH  = TICK_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_target_value,
    input  logic [TICK_WIDTH-1:0]  i_tick_now,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH-1:0] o_output_value,
    output logic                   o_at_target,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [RATE_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [RATE_W-1:0]      r_rise_rate;
    logic [RATE_W-1:0]      r_fall_rate;
    logic                   r_mirror;

    // input register stage
    logic                   r_in_valid;
    t_cmd                   r_cmd;
    logic [VALUE_WIDTH-1:0] r_target;
    logic [TICK_WIDTH-1:0]  r_tick;

    // ramp state
    logic [VALUE_WIDTH-1:0] r_ramp_output;
    logic                   r_armed;
    logic [TICK_WIDTH-1:0]  r_last_tick;

    // result register stage
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_at;

    logic                   w_out_free;
    logic                   w_fire;
    logic [VALUE_WIDTH-1:0] n_ramp_output;
    logic                   n_at_target;

    // result register can take a new value when empty or being drained
    assign w_out_free = !r_out_valid || !i_stall;
    // the held request completes its step this cycle
    assign w_fire     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_output_value = r_out_value;
    assign o_at_target    = r_out_at;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_rate <= RATE_RESET;
            r_fall_rate <= RATE_RESET;
            r_mirror    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RISE_RATE:   r_rise_rate <= i_cfg_data;
                CFG_FALL_RATE:   r_fall_rate <= i_cfg_data;
                CFG_MIRROR_MODE: r_mirror    <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    // input register: loads whenever it is not holding a stalled request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_target <= i_target_value;
            r_tick   <= i_tick_now;
        end
    end

    srl_step #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_step (
        .i_cmd       (r_cmd),
        .i_target    (r_target),
        .i_tick      (r_tick),
        .i_output    (r_ramp_output),
        .i_armed     (r_armed),
        .i_last_tick (r_last_tick),
        .i_rise_rate (r_rise_rate),
        .i_fall_rate (r_fall_rate),
        .i_mirror    (r_mirror),
        .o_output    (n_ramp_output),
        .o_at_target (n_at_target)
    );

    // ramp state advances once per completed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_output <= '0;
            r_armed       <= 1'b0;
            r_last_tick   <= '0;
        end else if (w_fire) begin
            r_ramp_output <= n_ramp_output;
            if (r_cmd == CMD_REFRESH) begin
                // refresh disarms, last tick kept
                r_armed <= 1'b0;
            end else begin
                r_armed     <= 1'b1;
                r_last_tick <= r_tick;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_value <= n_ramp_output;
            r_out_at    <= n_at_target;
        end
    end

    // refresh lands on its value and leaves the ramp disarmed
    a_refresh_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_REFRESH) |=> (o_at_target && !r_armed && o_valid))
        else $error("refresh did not force the output");

    // first update after reset or refresh keeps the output
    a_first_update_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_UPDATE && !r_armed)
        |=> (r_ramp_output == $past(r_ramp_output) && r_armed))
        else $error("unarmed update moved the output");

    // ramp state only moves when a request completes
    a_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_ramp_output) && $stable(r_last_tick)))
        else $error("ramp state changed without a request");

    // back pressure only when both stages are occupied
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("request stalled with room in the pipeline");

endmodule

>>> design/srl_step.sv
// ----------------------------------------------------------------------------
// srl_step: next output of the ramp
// Combinational step: picks the rate, scales it by elapsed ticks, snaps or
// moves the output toward the new setpoint.
// ----------------------------------------------------------------------------
module srl_step
    import srl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TICK_WIDTH  = TICK_W_DEF
) (
    input  t_cmd                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_target,
    input  logic [TICK_WIDTH-1:0]  i_tick,
    input  logic [VALUE_WIDTH-1:0] i_output,
    input  logic                   i_armed,
    input  logic [TICK_WIDTH-1:0]  i_last_tick,
    input  logic [RATE_W-1:0]      i_rise_rate,
    input  logic [RATE_W-1:0]      i_fall_rate,
    input  logic                   i_mirror,
    output logic [VALUE_WIDTH-1:0] o_output,
    output logic                   o_at_target
);

    localparam int PROD_W = RATE_W + TICK_WIDTH;
    localparam int CMP_W  = (PROD_W > VALUE_WIDTH) ? PROD_W : VALUE_WIDTH;

    logic signed [VALUE_WIDTH:0] w_tgt_x;
    logic signed [VALUE_WIDTH:0] w_out_x;
    logic signed [VALUE_WIDTH:0] w_diff;
    logic                        w_rising;
    logic                        w_use_rise;
    logic [RATE_W-1:0]           w_rate;
    logic [TICK_WIDTH-1:0]       w_elapsed;
    logic [PROD_W-1:0]           w_step;
    logic [CMP_W-1:0]            w_step_x;
    logic [CMP_W-1:0]            w_dist_x;
    logic                        w_snap;

    assign w_tgt_x  = {i_target[VALUE_WIDTH-1], i_target};
    assign w_out_x  = {i_output[VALUE_WIDTH-1], i_output};
    assign w_rising = (w_tgt_x >= w_out_x);
    assign w_diff   = w_rising ? (w_tgt_x - w_out_x) : (w_out_x - w_tgt_x);

    // mirror mode swaps the rates while the output is negative
    assign w_use_rise = w_rising ^ (i_mirror & i_output[VALUE_WIDTH-1]);
    assign w_rate     = w_use_rise ? i_rise_rate : i_fall_rate;
    assign w_elapsed  = i_tick - i_last_tick;
    assign w_step     = PROD_W'(w_rate) * PROD_W'(w_elapsed);

    assign w_step_x = CMP_W'(w_step);
    assign w_dist_x = CMP_W'(w_diff[VALUE_WIDTH-1:0]);
    assign w_snap   = (w_step_x >= w_dist_x);

    always_comb begin
        o_output = i_output;
        case (i_cmd)
            CMD_REFRESH: begin
                o_output = i_target;
            end
            CMD_UPDATE: begin
                if (i_armed && (i_target != i_output)) begin
                    if (w_snap) begin
                        o_output = i_target;
                    end else if (w_rising) begin
                        o_output = i_output + w_step_x[VALUE_WIDTH-1:0];
                    end else begin
                        o_output = i_output - w_step_x[VALUE_WIDTH-1:0];
                    end
                end
            end
            default: begin
                o_output = i_output;
            end
        endcase
    end

    assign o_at_target = (o_output == i_target);

endmodule

>>> dv/srl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_checker: ramp predictor and result scoreboard for the setpoint ramp limiter
// Watches the request, result and config channels. It keeps its own copy of
// the ramp state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module srl_checker
    import srl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TICK_WIDTH  = TICK_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_stall,
    input  logic                   i_req_cmd,
    input  logic [VALUE_WIDTH-1:0] i_req_value,
    input  logic [TICK_WIDTH-1:0]  i_req_tick,
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  logic [VALUE_WIDTH-1:0] i_res_value,
    input  logic                   i_res_at_target,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [RATE_W-1:0]      i_cfg_data,
    output int                     o_pending,
    output int                     o_errors
);

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   at_target;
    } t_ramp_result;

    logic [RATE_W-1:0]     rise_rate_q;
    logic [RATE_W-1:0]     fall_rate_q;
    logic                  mirror_q;
    longint                setpoint_q;
    longint                ramp_q;
    bit                    armed_q;
    logic [TICK_WIDTH-1:0] last_tick_q;
    t_ramp_result          expected_q[$];
    int                    mismatches = 0;

    function automatic t_ramp_result ramp_predict(t_cmd cmd, longint target,
                                                  logic [TICK_WIDTH-1:0] tick);
        t_ramp_result          res;
        logic [RATE_W-1:0]     rate;
        logic [TICK_WIDTH-1:0] elapsed;
        longint unsigned       step;
        longint unsigned       span;
        bit                    rising;
        if (cmd == CMD_REFRESH) begin
            setpoint_q = target;
            ramp_q     = target;
            armed_q    = 1'b0;
        end else begin
            rising     = target >= ramp_q;
            setpoint_q = target;
            if (armed_q && setpoint_q != ramp_q) begin
                // mirror mode swaps the rates while the output is below zero
                if (mirror_q && ramp_q < 0)
                    rate = rising ? fall_rate_q : rise_rate_q;
                else
                    rate = rising ? rise_rate_q : fall_rate_q;
                elapsed = tick - last_tick_q;
                step    = 64'(rate) * 64'(elapsed);
                span    = rising ? 64'(setpoint_q - ramp_q) : 64'(ramp_q - setpoint_q);
                if (step >= span)
                    ramp_q = setpoint_q;
                else if (rising)
                    ramp_q = ramp_q + longint'(step);
                else
                    ramp_q = ramp_q - longint'(step);
            end
            armed_q     = 1'b1;
            last_tick_q = tick;
        end
        res.value     = VALUE_WIDTH'(ramp_q);
        res.at_target = (ramp_q == setpoint_q);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_ramp_result want;
        if (!i_rst_n) begin
            rise_rate_q = RATE_RESET;
            fall_rate_q = RATE_RESET;
            mirror_q    = 1'b0;
            setpoint_q  = 0;
            ramp_q      = 0;
            armed_q     = 1'b0;
            last_tick_q = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RISE_RATE:   rise_rate_q = i_cfg_data;
                    CFG_FALL_RATE:   fall_rate_q = i_cfg_data;
                    CFG_MIRROR_MODE: mirror_q    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: output_value %0d",
                           $signed(i_res_value));
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_value !== want.value) begin
                        $error("output_value: expected %0d, got %0d",
                               $signed(want.value), $signed(i_res_value));
                        mismatches++;
                    end
                    if (i_res_at_target !== want.at_target) begin
                        $error("at_target: expected %0b, got %0b",
                               want.at_target, i_res_at_target);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_q.push_back(ramp_predict(t_cmd'(i_req_cmd),
                                                  longint'($signed(i_req_value)),
                                                  i_req_tick));
        end
        o_pending <= expected_q.size();
        o_errors  <= mismatches;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for the setpoint ramp limiter
// Drives directed and random setpoint updates and refreshes under several
// rate settings, with random idling on both channels; a checker module
// predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module tb;
    import srl_pkg::*;

    localparam int VW          = VALUE_W_DEF;
    localparam int TW          = TICK_W_DEF;
    localparam int Q           = 65536;     // 1.0 in q16.16
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 270;
    localparam int CYCLE_LIMIT = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic          i_cmd;
    logic [VW-1:0] i_target_value;
    logic [TW-1:0] i_tick_now;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [VW-1:0] o_output_value;
    logic          o_at_target;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [RATE_W-1:0]    i_cfg_data;

    int pending;
    int fail_count;

    // run statistics for the closing summary
    int n_req      = 0;
    int n_refresh  = 0;
    int n_settings = 0;
    int n_mirror   = 0;
    int cycle_count = 0;

    // random idling on both sides is enabled per phase
    bit          idle_en    = 1'b1;
    int unsigned stall_left = 0;

    setpoint_ramp_limiter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_target_value (i_target_value),
        .i_tick_now     (i_tick_now),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_output_value (o_output_value),
        .o_at_target    (o_at_target),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    srl_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_cmd       (i_cmd),
        .i_req_value     (i_target_value),
        .i_req_tick      (i_tick_now),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_value     (o_output_value),
        .i_res_at_target (o_at_target),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_errors        (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall: random bursts, none while idling is off
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_en) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("setpoint_ramp_limiter test failed");
        $finish;
    end

    // present one request and hold it until taken; valid stays high so a
    // back-to-back request does not toggle it within one time step
    task automatic send_req(t_cmd cmd, logic [VW-1:0] value, logic [TW-1:0] tick);
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_target_value <= value;
        i_tick_now     <= tick;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        n_req++;
        if (cmd == CMD_REFRESH)
            n_refresh++;
    endtask

    // sender gap
    task automatic hold_off(int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending until every outstanding request has its result, then let
    // the two-stage pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [RATE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // full register setting; only called with the block idle
    task automatic set_rates(logic [RATE_W-1:0] rise, logic [RATE_W-1:0] fall,
                             logic mirror);
        write_reg(CFG_RISE_RATE, rise);
        write_reg(CFG_FALL_RATE, fall);
        write_reg(CFG_MIRROR_MODE, {{(RATE_W-1){1'b0}}, mirror});
        i_cfg_valid <= 1'b0;
        n_settings++;
        if (mirror)
            n_mirror++;
    endtask

    // rates from crawling to maximal, zero included
    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 255);
            1:       return $urandom_range(32'h1000, 32'h10_0000);
            2:       return $urandom_range(0, 3);
            3:       return $urandom();
            4:       return 32'hffff_ffff;
            default: return RATE_RESET;
        endcase
    endfunction

    // mostly keep chasing the same setpoint so ramps run to completion,
    // sometimes nudge it, sometimes jump anywhere or to an extreme
    function automatic logic [VW-1:0] pick_value(logic [VW-1:0] goal);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return goal;
        else if (sel < 80)
            return goal + VW'($urandom_range(0, 1 << 25)) - VW'(1 << 24);
        else if (sel < 95)
            return VW'($urandom());
        case ($urandom_range(0, 3))
            0:       return {1'b0, {(VW-1){1'b1}}};
            1:       return {1'b1, {(VW-1){1'b0}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // ticks mostly advance a little; now and then far, at random, or backward
    // so the elapsed count wraps
    function automatic logic [TW-1:0] next_tick(logic [TW-1:0] tick);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return tick + TW'($urandom_range(0, 8));
        else if (sel < 88)
            return tick + TW'($urandom_range(9, 2000));
        else if (sel < 94)
            return TW'($urandom());
        return tick - TW'($urandom_range(1, 16));
    endfunction

    initial begin
        logic [VW-1:0] goal;
        logic [TW-1:0] tick;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_UPDATE;
        i_target_value <= '0;
        i_tick_now     <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_RISE_RATE;
        i_cfg_data     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset rates (5.0 per tick both ways, no mirror) ----
        send_req(CMD_UPDATE, 100 * Q, 10);           // first update only arms
        send_req(CMD_UPDATE, 100 * Q, 12);           // two ticks up: 10.0
        send_req(CMD_UPDATE, 100 * Q, 12);           // no ticks elapsed, holds
        send_req(CMD_UPDATE, 100 * Q, 40);           // step passes target, snaps
        send_req(CMD_UPDATE, 100 * Q, 41);           // already at setpoint
        send_req(CMD_UPDATE, -100 * Q, 43);          // falls by 10.0
        send_req(CMD_REFRESH, 32'h7fff_ffff, 0);     // force max, disarm
        send_req(CMD_UPDATE, 32'h8000_0000, 0);      // re-arm after refresh
        send_req(CMD_UPDATE, 32'h8000_0000, 32'hffff_ffff); // huge step to min
        send_req(CMD_REFRESH, 32'h8000_0000, 32'h5555_5555);
        send_req(CMD_UPDATE, 32'h7fff_ffff, 5);
        send_req(CMD_UPDATE, 32'h7fff_ffff, 4);      // elapsed wraps to all ones
        send_req(CMD_REFRESH, 0, 32'haaaa_aaaa);
        send_req(CMD_UPDATE, 1, 32'hffff_fffe);
        send_req(CMD_UPDATE, 1, 1);                  // tick counter wraps
        send_req(CMD_UPDATE, 0, 1);                  // zero elapsed, output stays
        drain();

        // ---- directed, zero rise rate, one-lsb fall rate, mirror on ----
        set_rates('0, 1, 1'b1);
        i_cfg_valid <= 1'b1;                         // unused index is dropped
        i_cfg_index <= CFG_IDX_W'(3);
        i_cfg_data  <= '1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        send_req(CMD_REFRESH, -50 * Q, 0);
        send_req(CMD_UPDATE, -10 * Q, 100);
        send_req(CMD_UPDATE, -10 * Q, 110);          // negative and rising: fall rate
        send_req(CMD_UPDATE, -60 * Q, 120);          // negative and falling: zero rate
        send_req(CMD_REFRESH, 5 * Q, 0);
        send_req(CMD_UPDATE, 6 * Q, 0);
        send_req(CMD_UPDATE, 6 * Q, 1000);           // positive, zero rise rate holds
        send_req(CMD_UPDATE, 4 * Q, 2000);           // falls 1000 lsb
        drain();

        // ---- directed, maximal rates: step equal to the full-scale distance ----
        set_rates('1, '1, 1'b0);
        send_req(CMD_REFRESH, 32'h8000_0000, 0);
        send_req(CMD_UPDATE, 32'h7fff_ffff, 500);
        send_req(CMD_UPDATE, 32'h7fff_ffff, 501);
        drain();

        // ---- random phases, one register setting each ----
        goal = '0;
        tick = TW'($urandom());
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_rates(pick_rate(), pick_rate(), 1'($urandom_range(0, 1)));
            // last phase runs without idling; others mostly with it
            idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (idle_en && $urandom_range(0, 5) == 0)
                    hold_off($urandom_range(1, 5));
                if ($urandom_range(0, 299) == 0)
                    drain();
                if ($urandom_range(0, 15) == 0) begin
                    goal = pick_value(goal);
                    send_req(CMD_REFRESH, goal, TW'($urandom()));
                end else begin
                    goal = pick_value(goal);
                    tick = next_tick(tick);
                    send_req(CMD_UPDATE, goal, tick);
                end
            end
        end
        drain();

        $display("covered %0d requests (%0d refreshes) under %0d register settings,",
                 n_req, n_refresh, n_settings);
        $display("%0d of them with mirrored rates, with random idling on both sides",
                 n_mirror);
        if (fail_count == 0)
            $display("setpoint_ramp_limiter test passed");
        else
            $display("setpoint_ramp_limiter test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/srl_pkg.sv
design/srl_step.sv
design/setpoint_ramp_limiter.sv
dv/srl_checker.sv
dv/tb.sv
